// ----- rtl/scs_pkg.sv -----
// Shared types and constants for the sieve CRT solver.
`timescale 1ns / 1ps
package scs_pkg;

   localparam int unsigned FIELD_W       = 16;
   localparam int unsigned OUT_W         = 63;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned MODULUS_BITS_DEF = 16;
   localparam int unsigned TIME_BITS_DEF    = 63;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_NOSOL = 2'd1,
      ST_OVF   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_REDUCE,
      S_FOLD,
      S_SEARCH,
      S_MULT,
      S_CHECK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic set_nosol;
      logic reduce;
      logic fold;
      logic search;
      logic mult_load;
      logic mult;
      logic commit;
      logic out_write;
   } cmd_type;

   typedef struct packed {
      logic err_ok;
      logic m_zero;
      logic reduce_last;
      logic found;
      logic exhausted;
      logic mult_last;
      logic rsp_busy;
   } stat_type;

endpackage

// ----- rtl/scs_channel_if.sv -----
// Request and response channel interfaces of the sieve CRT solver.
`timescale 1ns / 1ps
interface scs_req_if;
   import scs_pkg::*;
   logic               valid;
   logic               ready;
   logic               first_disc;
   logic [FIELD_W-1:0] disc_number;
   logic [FIELD_W-1:0] disc_positions;
   logic [FIELD_W-1:0] start_position;

   modport source (output valid, first_disc, disc_number, disc_positions, start_position,
                   input ready);
   modport sink   (input valid, first_disc, disc_number, disc_positions, start_position,
                   output ready);
endinterface

interface scs_rsp_if;
   import scs_pkg::*;
   logic                valid;
   logic                ready;
   logic [OUT_W-1:0]    solution_time;
   logic [OUT_W-1:0]    combined_period;
   logic [STATUS_W-1:0] status;

   modport source (output valid, solution_time, combined_period, status, input ready);
   modport sink   (input valid, solution_time, combined_period, status, output ready);
endinterface

// ----- rtl/scs_ctrl.sv -----
// Sequencing state machine of the sieve CRT solver.
`timescale 1ns / 1ps
module scs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  scs_pkg::stat_type stat,
   output scs_pkg::cmd_type  cmd
);
   import scs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_START;
         S_START: begin
            if (!stat.err_ok || stat.m_zero) state_in = S_DONE;
            else state_in = S_REDUCE;
         end
         S_REDUCE: if (stat.reduce_last) state_in = S_FOLD;
         S_FOLD:   state_in = S_SEARCH;
         S_SEARCH: begin
            priority if (stat.found) state_in = S_MULT;
            else if (stat.exhausted) state_in = S_DONE;
            else state_in = S_SEARCH;
         end
         S_MULT:   if (stat.mult_last) state_in = S_CHECK;
         S_CHECK:  state_in = S_DONE;
         S_DONE:   if (!stat.rsp_busy) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_START: begin
            cmd.prep      = 1'b1;
            cmd.set_nosol = stat.err_ok && stat.m_zero;
         end
         S_REDUCE: cmd.reduce = 1'b1;
         S_FOLD:   cmd.fold   = 1'b1;
         S_SEARCH: begin
            cmd.search    = 1'b1;
            cmd.mult_load = stat.found;
            cmd.set_nosol = !stat.found && stat.exhausted;
         end
         S_MULT:   cmd.mult      = 1'b1;
         S_CHECK:  cmd.commit    = 1'b1;
         S_DONE:   cmd.out_write = !stat.rsp_busy;
         default: ;
      endcase
   end

endmodule

// ----- rtl/scs_dpath.sv -----
// Datapath of the sieve CRT solver: remainders, search, products and state.
`timescale 1ns / 1ps
module scs_dpath #(
   parameter int unsigned MODULUS_BITS = scs_pkg::MODULUS_BITS_DEF,
   parameter int unsigned TIME_BITS    = scs_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  scs_pkg::cmd_type              cmd,
   output scs_pkg::stat_type             stat,
   input  logic                          rsp_busy,
   input  logic                          first_disc,
   input  logic [scs_pkg::FIELD_W-1:0]   disc_number,
   input  logic [scs_pkg::FIELD_W-1:0]   disc_positions,
   input  logic [scs_pkg::FIELD_W-1:0]   start_position,
   output logic [scs_pkg::OUT_W-1:0]     solution_time,
   output logic [scs_pkg::OUT_W-1:0]     combined_period,
   output logic [scs_pkg::STATUS_W-1:0]  status
);
   import scs_pkg::*;

   localparam int unsigned MB = MODULUS_BITS;
   localparam int unsigned TB = TIME_BITS;
   localparam int unsigned SW = FIELD_W + 1;
   localparam int unsigned RW = (TB > SW) ? TB : SW;
   localparam int unsigned PW = TB + MB;
   localparam int unsigned CW = $clog2((RW > MB) ? RW : MB);

   function automatic logic [MB-1:0] mod_step(input logic [MB-1:0] rem, input logic b,
                                              input logic [MB-1:0] m);
      logic [MB:0] t;
      t = {rem, b};
      if (t >= {1'b0, m}) t = t - {1'b0, m};
      return t[MB-1:0];
   endfunction

   // architectural state
   logic [TB-1:0] time_ff, time_in;
   logic [TB-1:0] period_ff, period_in;
   status_type    err_ff, err_in;

   // working registers
   logic [MB-1:0] m_ff;
   logic [RW-1:0] tsh_ff, psh_ff, rsh_ff;
   logic [MB-1:0] rem_t_ff, rem_p_ff, rem_r_ff;
   logic [CW-1:0] cnt_ff;
   logic [MB-1:0] v_ff, s_ff, k_ff;
   logic [MB-1:0] kq_ff, mq_ff;
   logic [PW-1:0] kp_ff, mp_ff;
   logic [OUT_W-1:0]    sol_ff, per_ff;
   logic [STATUS_W-1:0] stat_out_ff;

   logic [MB:0]   fold_sum;
   logic [MB:0]   v_sum;
   logic [PW:0]   t_sum;
   logic          ovf;

   assign fold_sum = {1'b0, rem_t_ff} + {1'b0, rem_r_ff};
   assign v_sum    = {1'b0, v_ff} + {1'b0, s_ff};
   assign t_sum    = {1'b0, kp_ff} + (PW+1)'(time_ff);
   assign ovf      = (|t_sum[PW:TB]) || (|mp_ff[PW-1:TB]);

   always_comb begin
      time_in   = time_ff;
      period_in = period_ff;
      err_in    = err_ff;
      if (cmd.load && first_disc) begin
         time_in   = '0;
         period_in = TB'(1);
         err_in    = ST_OK;
      end
      if (cmd.set_nosol) err_in = ST_NOSOL;
      if (cmd.commit) begin
         if (ovf) begin
            err_in = ST_OVF;
         end else begin
            time_in   = t_sum[TB-1:0];
            period_in = mp_ff[TB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff   <= '0;
         period_ff <= TB'(1);
         err_ff    <= ST_OK;
      end else begin
         time_ff   <= time_in;
         period_ff <= period_in;
         err_ff    <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         m_ff   <= MB'(disc_positions);
         rsh_ff <= RW'({1'b0, disc_number} + {1'b0, start_position});
      end
      if (cmd.prep) begin
         tsh_ff   <= RW'(time_ff);
         psh_ff   <= RW'(period_ff);
         rem_t_ff <= '0;
         rem_p_ff <= '0;
         rem_r_ff <= '0;
         cnt_ff   <= CW'(RW - 1);
      end
      if (cmd.reduce) begin
         rem_t_ff <= mod_step(rem_t_ff, tsh_ff[RW-1], m_ff);
         rem_p_ff <= mod_step(rem_p_ff, psh_ff[RW-1], m_ff);
         rem_r_ff <= mod_step(rem_r_ff, rsh_ff[RW-1], m_ff);
         tsh_ff   <= {tsh_ff[RW-2:0], 1'b0};
         psh_ff   <= {psh_ff[RW-2:0], 1'b0};
         rsh_ff   <= {rsh_ff[RW-2:0], 1'b0};
         cnt_ff   <= cnt_ff - CW'(1);
      end
      if (cmd.fold) begin
         v_ff <= (fold_sum >= {1'b0, m_ff}) ? MB'(fold_sum - {1'b0, m_ff}) : fold_sum[MB-1:0];
         s_ff <= rem_p_ff;
         k_ff <= '0;
      end
      if (cmd.search && !stat.found && !stat.exhausted) begin
         v_ff <= (v_sum >= {1'b0, m_ff}) ? MB'(v_sum - {1'b0, m_ff}) : v_sum[MB-1:0];
         k_ff <= k_ff + MB'(1);
      end
      if (cmd.mult_load) begin
         kq_ff  <= k_ff;
         mq_ff  <= m_ff;
         kp_ff  <= '0;
         mp_ff  <= '0;
         cnt_ff <= CW'(MB - 1);
      end
      if (cmd.mult) begin
         kp_ff  <= {kp_ff[PW-2:0], 1'b0} + (kq_ff[MB-1] ? PW'(period_ff) : '0);
         mp_ff  <= {mp_ff[PW-2:0], 1'b0} + (mq_ff[MB-1] ? PW'(period_ff) : '0);
         kq_ff  <= {kq_ff[MB-2:0], 1'b0};
         mq_ff  <= {mq_ff[MB-2:0], 1'b0};
         cnt_ff <= cnt_ff - CW'(1);
      end
      if (cmd.out_write) begin
         sol_ff      <= OUT_W'(time_ff);
         per_ff      <= OUT_W'(period_ff);
         stat_out_ff <= err_ff;
      end
   end

   always_comb begin
      stat.err_ok      = (err_ff == ST_OK);
      stat.m_zero      = (m_ff == '0);
      stat.reduce_last = (cnt_ff == '0);
      stat.found       = (v_ff == '0);
      stat.exhausted   = (k_ff == m_ff - MB'(1));
      stat.mult_last   = (cnt_ff == '0);
      stat.rsp_busy    = rsp_busy;
   end

   assign solution_time   = sol_ff;
   assign combined_period = per_ff;
   assign status          = stat_out_ff;

endmodule

// ----- rtl/sieve_crt_solver.sv -----
// Top level of the sieve CRT solver: controller, datapath and response register.
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------------
//  req_ch   | in        | first_disc, disc_number, disc_positions, start_position
//  rsp_ch   | out       | solution_time, combined_period, status
//
// An item runs a bit-serial remainder pass over RW = max(TIME_BITS, 17) bits, a search
// that steps k up to the number of periods added, and a serial multiply over
// MODULUS_BITS bits. A held error skips straight to the result.
// Reset is synchronous and restores time 0, period 1, status ok.
// A new item is taken while a result waits; the next result holds until it is taken.
`timescale 1ns / 1ps
module sieve_crt_solver #(
   parameter int unsigned MODULUS_BITS = scs_pkg::MODULUS_BITS_DEF,
   parameter int unsigned TIME_BITS    = scs_pkg::TIME_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   scs_req_if.sink   req_ch,
   scs_rsp_if.source rsp_ch
);
   import scs_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_busy;

   assign rsp_busy = rsp_valid_ff && !rsp_ch.ready;

   scs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   scs_dpath #(
      .MODULUS_BITS (MODULUS_BITS),
      .TIME_BITS    (TIME_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_busy        (rsp_busy),
      .first_disc      (req_ch.first_disc),
      .disc_number     (req_ch.disc_number),
      .disc_positions  (req_ch.disc_positions),
      .start_position  (req_ch.start_position),
      .solution_time   (rsp_ch.solution_time),
      .combined_period (rsp_ch.combined_period),
      .status          (rsp_ch.status)
   );

   always_comb begin
      priority if (cmd.out_write) rsp_valid_in = 1'b1;
      else if (rsp_ch.ready)      rsp_valid_in = 1'b0;
      else                        rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("controller stayed ready after taking an item");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_write |-> !req_ch.ready && !rsp_busy)
      else $error("result written while idle or while output stalled");

   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == ST_OK) |-> (rsp_ch.combined_period != '0))
      else $error("zero period reported with ok status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      cmd.out_write |=> (rsp_ch.status == ST_OK) || (rsp_ch.status == ST_NOSOL) ||
                        (rsp_ch.status == ST_OVF))
      else $error("undefined status code in result");

endmodule

// ----- dv/scs_checker.sv -----
// Checker for the sieve CRT solver: watches both channels, predicts each result and compares.
`timescale 1ns / 1ps
module scs_checker (
   input  logic        clock,
   input  logic        reset,
   scs_req_if          req_mon,
   scs_rsp_if          rsp_mon,
   output int unsigned mismatches,
   output int unsigned outstanding
);
   import scs_pkg::*;

   typedef struct packed {
      logic [OUT_W-1:0] solution_time;
      logic [OUT_W-1:0] combined_period;
      status_type       status;
   } solution_type;

   localparam logic [63:0] TIME_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   logic [63:0]  sieve_time;
   logic [63:0]  sieve_period;
   status_type   sieve_status;
   solution_type pending_solutions[$];

   // fold one congruence (t + residue) mod m == 0 into the running solution
   function automatic void add_disc(input logic [63:0] num, input logic [63:0] m,
                                    input logic [63:0] start);
      logic [63:0] residue;
      logic [63:0] v;
      logic [63:0] s;
      logic [63:0] k;
      logic        found;
      if (m == 0) begin
         sieve_status = ST_NOSOL;
         return;
      end
      residue = (num + start) % m;
      v       = ((sieve_time % m) + residue) % m;
      s       = sieve_period % m;
      found   = 1'b0;
      for (k = 0; k < m; k++) begin
         if (v == 0) begin
            found = 1'b1;
            break;
         end
         v = v + s;
         if (v >= m)
            v = v - m;
      end
      if (!found) begin
         sieve_status = ST_NOSOL;
         return;
      end
      if (k != 0 && sieve_period > (TIME_MAX - sieve_time) / k) begin
         sieve_status = ST_OVF;
         return;
      end
      if (sieve_period > TIME_MAX / m) begin
         sieve_status = ST_OVF;
         return;
      end
      sieve_time   = sieve_time + k * sieve_period;
      sieve_period = sieve_period * m;
   endfunction

   always @(posedge clock) begin
      solution_type want;
      int unsigned  errs;
      errs = 0;
      if (reset) begin
         sieve_time   = 64'd0;
         sieve_period = 64'd1;
         sieve_status = ST_OK;
         pending_solutions.delete();
         mismatches  <= 0;
         outstanding <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.first_disc) begin
               sieve_time   = 64'd0;
               sieve_period = 64'd1;
               sieve_status = ST_OK;
            end
            if (sieve_status == ST_OK)
               add_disc(64'(req_mon.disc_number), 64'(req_mon.disc_positions),
                        64'(req_mon.start_position));
            want = '{sieve_time[OUT_W-1:0], sieve_period[OUT_W-1:0], sieve_status};
            pending_solutions = {pending_solutions, want};
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_solutions.size() == 0) begin
               $error("unexpected result: solution_time %0d combined_period %0d status %0d",
                      rsp_mon.solution_time, rsp_mon.combined_period, rsp_mon.status);
               errs++;
            end else begin
               want = pending_solutions.pop_front();
               if (rsp_mon.solution_time !== want.solution_time) begin
                  $error("solution_time mismatch: expected %0d, actual %0d",
                         want.solution_time, rsp_mon.solution_time);
                  errs++;
               end
               if (rsp_mon.combined_period !== want.combined_period) begin
                  $error("combined_period mismatch: expected %0d, actual %0d",
                         want.combined_period, rsp_mon.combined_period);
                  errs++;
               end
               if (rsp_mon.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_mon.status);
                  errs++;
               end
            end
         end
         mismatches  <= mismatches + errs;
         outstanding <= pending_solutions.size();
      end
   end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the sieve CRT solver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
   import scs_pkg::*;

   localparam int unsigned SMALL_PRIMES [0:39] = '{
      2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67, 71,
      73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127, 131, 137, 139, 149, 151,
      157, 163, 167, 173
   };

   logic        clock = 1'b0;
   logic        reset;
   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned discs_sent         = 0;

   scs_req_if req_ch ();
   scs_rsp_if rsp_ch ();

   sieve_crt_solver u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   scs_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic send_disc(input logic first, input logic [15:0] num,
                            input logic [15:0] positions, input logic [15:0] start);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.first_disc     <= first;
      req_ch.disc_number    <= num;
      req_ch.disc_positions <= positions;
      req_ch.start_position <= start;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      discs_sent++;
   endtask

   // coprime discs: solvable until the period overflows
   task automatic prime_chain();
      int unsigned pool [0:39];
      int unsigned len;
      int unsigned pick;
      int unsigned swap_v;
      logic [15:0] base;
      pool = SMALL_PRIMES;
      len  = $urandom_range(1, 20);
      base = 16'($urandom);
      for (int unsigned j = 0; j < len; j++) begin
         pick       = $urandom_range(39, j);
         swap_v     = pool[j];
         pool[j]    = pool[pick];
         pool[pick] = swap_v;
         send_disc(j == 0, base + 16'(j), 16'(pool[j]), 16'($urandom));
      end
   endtask

   task automatic rough_chain(input int unsigned max_mod, input int unsigned max_len);
      int unsigned len;
      len = $urandom_range(1, max_len);
      for (int unsigned j = 0; j < len; j++)
         send_disc(j == 0, 16'($urandom), 16'($urandom_range(max_mod, 0)), 16'($urandom));
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned target;
      int unsigned pick;
      target = discs_sent + count;
      while (discs_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 60)
            prime_chain();
         else if (pick < 78)
            rough_chain(64, 8);
         else if (pick < 90)
            send_disc(1'($urandom_range(1)), 16'($urandom), 16'($urandom_range(32, 0)),
                      16'($urandom));
         else if (pick < 98)
            rough_chain(4095, 3);
         else begin
            send_disc(1'b1, 16'($urandom), 16'($urandom_range(65535, 32768)), 16'($urandom));
            send_disc(1'b0, 16'($urandom), 16'($urandom_range(65535, 1)), 16'($urandom));
         end
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.first_disc     <= 1'b0;
      req_ch.disc_number    <= '0;
      req_ch.disc_positions <= '0;
      req_ch.start_position <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // single-position disc, then the widest disc with all-ones fields
      send_disc(1'b1, 16'd0, 16'd1, 16'd0);
      send_disc(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // zero modulus, then a held error
      send_disc(1'b1, 16'd7, 16'd0, 16'd3);
      send_disc(1'b0, 16'd1, 16'd5, 16'd2);
      // restart, then a disc sharing a factor with the period: no solution
      send_disc(1'b1, 16'd1, 16'd2, 16'd0);
      send_disc(1'b0, 16'd0, 16'd4, 16'd0);
      send_disc(1'b0, 16'd2, 16'd3, 16'd0);
      // classic two-disc puzzle
      send_disc(1'b1, 16'd1, 16'd5, 16'd4);
      send_disc(1'b0, 16'd2, 16'd2, 16'd1);
      // large primes until the period overflows, then a held overflow
      send_disc(1'b1, 16'd0, 16'd65521, 16'd0);
      send_disc(1'b0, 16'd1, 16'd65519, 16'd40000);
      send_disc(1'b0, 16'd2, 16'd65497, 16'd12345);
      send_disc(1'b0, 16'd3, 16'd65479, 16'd65535);
      send_disc(1'b0, 16'd4, 16'd65449, 16'd0);
      // overflow from a long chain of small primes
      for (int unsigned j = 0; j < 18; j++)
         send_disc(j == 0, 16'(j), 16'(SMALL_PRIMES[j]), 16'h8000 >> j);

      run_random(300);
      sender_idle_pct = 51;
      run_random(300);
      sender_idle_pct    = 0;
      receiver_stall_pct = 51;
      run_random(300);
      sender_idle_pct    = 22;
      receiver_stall_pct = 22;
      run_random(300);

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0)
         $display("sieve_crt_solver regression: pass");
      else
         $display("sieve_crt_solver regression: fail");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("sieve_crt_solver regression: fail");
      $finish;
   end

endmodule
